@@ rtl/bfncd_pkg.sv @@
package bfncd_pkg;

  localparam int MaxNodes   = 16;
  localparam int MaxEdges   = 64;
  localparam int WeightBits = 16;

  localparam int NodeIdxW = $clog2(MaxNodes);
  localparam int NodeCntW = $clog2(MaxNodes + 1);
  localparam int EdgeIdxW = $clog2(MaxEdges);
  localparam int EdgeCntW = $clog2(MaxEdges + 1);
  // distances never exceed MaxNodes*MaxEdges weights in magnitude
  localparam int DistW = WeightBits + $clog2(MaxNodes * MaxEdges) + 2;
  localparam int EdgeW = 2 * NodeIdxW + WeightBits;

  typedef enum logic [1:0] {
    OpAddNode = 2'd0,
    OpAddEdge = 2'd1,
    OpRemEdge = 2'd2,
    OpRun     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StFull     = 2'd1,
    StUnknown  = 2'd2,
    StNotFound = 2'd3
  } status_e;

  typedef struct packed {
    logic [NodeIdxW-1:0]   from;
    logic [NodeIdxW-1:0]   to;
    logic [WeightBits-1:0] w;
  } edge_t;

endpackage

@@ rtl/bfncd_ram.sv @@
module bfncd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/bellman_ford_negative_cycle_detector_unit.sv @@
// Bellman-Ford negative cycle detector. Node IDs, edges and distances live in
// RAMs with a registered read, and one item is handled at a time: an item is
// taken only in the idle state, its result is held on the output until taken,
// and the block is idle again in the next cycle. Add node goes from the idle
// state through SAfterFind to SDone, where its result shows. A node ID search
// reads, then checks, each table entry in turn and reports an unknown ID if
// none matches. Add edge runs a search for each endpoint, then writes the
// edge in SAfterFind. Remove edge runs both searches, scans the edges for the
// first match, then shifts every later edge down one slot. A run searches
// for the start, clears the 16 distances, then makes up to N-1 relaxation
// passes and one check pass, reading each valid edge and its distances.
module bellman_ford_negative_cycle_detector_unit
  import bfncd_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   op_i,
  input  logic [31:0]                  node_id_i,
  input  logic [31:0]                  src_id_i,
  input  logic [31:0]                  dest_id_i,
  input  logic signed [WeightBits-1:0] weight_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic                         negative_cycle_o
);

  typedef enum logic [3:0] {
    SIdle, SFindRd, SFindCk, SAfterFind, SEdgeRd, SEdgeCk, SShiftRd, SShiftWr,
    SClear, SPassRd, SPassSrc, SPassDst, SPassCk, SDone
  } state_e;

  state_e state_q;
  op_e    op_q;
  logic [31:0] nid_q, sid_q, did_q;
  logic [WeightBits-1:0] w_q;
  logic [NodeCntW-1:0] node_cnt_q;
  logic [EdgeCntW-1:0] edge_cnt_q;
  logic [NodeCntW-1:0] ni_q;       // node search index
  logic                which_q;    // 0: searching src, 1: dest
  logic [NodeIdxW-1:0] s_q, d_q;
  logic [EdgeCntW-1:0] ei_q;
  logic [NodeCntW-1:0] pass_q;
  logic                changed_q, check_q;
  logic [MaxNodes-1:0] reached_q;
  edge_t               cur_q;
  logic signed [DistW-1:0] dfrom_q;
  status_e status_q;
  logic    neg_q;

  // memory ports
  logic                node_we;
  logic [NodeIdxW-1:0] node_waddr, node_raddr;
  logic [31:0]         node_rdata;
  logic                edge_we;
  logic [EdgeIdxW-1:0] edge_waddr, edge_raddr;
  edge_t               edge_wdata, edge_rdata;
  logic                dist_we;
  logic [NodeIdxW-1:0] dist_waddr, dist_raddr;
  logic signed [DistW-1:0] dist_wdata, dist_rdata;

  bfncd_ram #(.Width(32), .Depth(MaxNodes)) u_nodes (
    .clk_i, .we_i(node_we), .waddr_i(node_waddr), .wdata_i(nid_q),
    .raddr_i(node_raddr), .rdata_o(node_rdata)
  );
  bfncd_ram #(.Width(EdgeW), .Depth(MaxEdges)) u_edges (
    .clk_i, .we_i(edge_we), .waddr_i(edge_waddr), .wdata_i(edge_wdata),
    .raddr_i(edge_raddr), .rdata_o(edge_rdata)
  );
  bfncd_ram #(.Width(DistW), .Depth(MaxNodes)) u_dist (
    .clk_i, .we_i(dist_we), .waddr_i(dist_waddr), .wdata_i(dist_wdata),
    .raddr_i(dist_raddr), .rdata_o(dist_rdata)
  );

  logic [31:0] want_id;
  logic signed [DistW-1:0] cand;
  logic better;
  logic relax_hit;
  logic [EdgeCntW-1:0] ei_prev;

  assign want_id   = which_q ? did_q : sid_q;
  assign cand      = dfrom_q + DistW'(signed'(cur_q.w));
  assign better    = !reached_q[cur_q.to] || (cand < dist_rdata);
  assign relax_hit = reached_q[cur_q.from] && better;
  assign ei_prev   = ei_q - 1'b1;

  // drive memory ports from the state
  always_comb begin
    node_we    = (state_q == SAfterFind) && (op_q == OpAddNode) &&
                 (node_cnt_q < NodeCntW'(MaxNodes));
    node_waddr = node_cnt_q[NodeIdxW-1:0];
    node_raddr = ni_q[NodeIdxW-1:0];
    edge_we    = 1'b0;
    edge_waddr = ei_q[EdgeIdxW-1:0];
    edge_wdata = '{from: s_q, to: d_q, w: w_q};
    edge_raddr = ei_q[EdgeIdxW-1:0];
    dist_we    = 1'b0;
    dist_waddr = ni_q[NodeIdxW-1:0];
    dist_wdata = '0;
    dist_raddr = cur_q.to;
    unique case (state_q)
      SAfterFind: begin
        edge_we    = (op_q == OpAddEdge) && (edge_cnt_q < EdgeCntW'(MaxEdges));
        edge_waddr = edge_cnt_q[EdgeIdxW-1:0];
      end
      SShiftWr: begin
        edge_we    = 1'b1;
        edge_waddr = ei_prev[EdgeIdxW-1:0];
        edge_wdata = edge_rdata;
      end
      SClear: dist_we = 1'b1;
      SPassSrc: dist_raddr = edge_rdata.from;
      SPassCk: begin
        dist_we    = !check_q && relax_hit;
        dist_waddr = cur_q.to;
        dist_wdata = cand;
      end
      default: ;
    endcase
  end

  assign in_ready_o       = (state_q == SIdle);
  assign out_valid_o      = (state_q == SDone);
  assign status_o         = status_q;
  assign negative_cycle_o = neg_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      node_cnt_q <= '0;
      edge_cnt_q <= '0;
      op_q       <= OpAddNode;
      nid_q      <= '0;
      sid_q      <= '0;
      did_q      <= '0;
      w_q        <= '0;
      ni_q       <= '0;
      which_q    <= 1'b0;
      s_q        <= '0;
      d_q        <= '0;
      ei_q       <= '0;
      pass_q     <= '0;
      changed_q  <= 1'b0;
      check_q    <= 1'b0;
      cur_q      <= '0;
      dfrom_q    <= '0;
      status_q   <= StOk;
      neg_q      <= 1'b0;
      reached_q  <= '0;
    end else begin
      unique case (state_q)
        SIdle: if (in_valid_i) begin
          op_q     <= op_e'(op_i);
          nid_q    <= node_id_i;
          sid_q    <= src_id_i;
          did_q    <= dest_id_i;
          w_q      <= weight_i;
          status_q <= StOk;
          neg_q    <= 1'b0;
          ni_q     <= '0;
          which_q  <= 1'b0;
          state_q  <= (op_e'(op_i) == OpAddNode) ? SAfterFind : SFindRd;
        end
        // search node table for the wanted ID
        SFindRd: begin
          if (ni_q >= node_cnt_q) begin
            status_q <= StUnknown;
            state_q  <= SDone;
          end else begin
            state_q <= SFindCk;
          end
        end
        SFindCk: begin
          if (node_rdata == want_id) begin
            if (which_q || op_q == OpRun) begin
              d_q     <= ni_q[NodeIdxW-1:0];
              state_q <= SAfterFind;
            end else begin
              s_q     <= ni_q[NodeIdxW-1:0];
              which_q <= 1'b1;
              ni_q    <= '0;
              state_q <= SFindRd;
            end
          end else begin
            ni_q    <= ni_q + 1'b1;
            state_q <= SFindRd;
          end
        end
        SAfterFind: begin
          ei_q <= '0;
          unique case (op_q)
            OpAddNode: begin
              if (node_cnt_q >= NodeCntW'(MaxNodes)) status_q <= StFull;
              else node_cnt_q <= node_cnt_q + 1'b1;
              state_q <= SDone;
            end
            OpAddEdge: begin
              if (edge_cnt_q >= EdgeCntW'(MaxEdges)) status_q <= StFull;
              else edge_cnt_q <= edge_cnt_q + 1'b1;
              state_q <= SDone;
            end
            OpRemEdge: state_q <= SEdgeRd;
            OpRun: begin
              s_q       <= d_q;
              ni_q      <= '0;
              reached_q <= '0;
              state_q   <= SClear;
            end
            default: state_q <= SDone;
          endcase
        end
        // look for the first matching edge to remove
        SEdgeRd: begin
          if (ei_q >= edge_cnt_q) begin
            status_q <= StNotFound;
            state_q  <= SDone;
          end else begin
            state_q <= SEdgeCk;
          end
        end
        SEdgeCk: begin
          ei_q <= ei_q + 1'b1;
          if (edge_rdata.from == s_q && edge_rdata.to == d_q) begin
            state_q <= SShiftRd;
          end else begin
            state_q <= SEdgeRd;
          end
        end
        // shift later edges down one slot; ei_q reads, ei_q-1 is written
        SShiftRd: begin
          if (ei_q >= edge_cnt_q) begin
            edge_cnt_q <= edge_cnt_q - 1'b1;
            state_q    <= SDone;
          end else begin
            state_q <= SShiftWr;
          end
        end
        SShiftWr: begin
          ei_q    <= ei_q + 1'b1;
          state_q <= SShiftRd;
        end
        // clear distances, then mark the start reached
        SClear: begin
          if (ni_q == NodeCntW'(MaxNodes - 1)) begin
            reached_q[s_q] <= 1'b1;
            pass_q         <= NodeCntW'(1);
            changed_q      <= 1'b0;
            check_q        <= (node_cnt_q <= NodeCntW'(1));
            ei_q           <= '0;
            state_q        <= SPassRd;
          end else begin
            ni_q <= ni_q + 1'b1;
          end
        end
        // read the next edge, or close the pass
        SPassRd: begin
          if (ei_q >= edge_cnt_q) begin
            ei_q      <= '0;
            changed_q <= 1'b0;
            if (check_q) begin
              state_q <= SDone;
            end else if (!changed_q || (pass_q + 1'b1 >= node_cnt_q)) begin
              check_q <= 1'b1;
            end else begin
              pass_q <= pass_q + 1'b1;
            end
          end else begin
            state_q <= SPassSrc;
          end
        end
        // hold the edge and read the source distance
        SPassSrc: begin
          cur_q   <= edge_rdata;
          state_q <= SPassDst;
        end
        // hold the source distance and read the destination distance
        SPassDst: begin
          dfrom_q <= dist_rdata;
          state_q <= SPassCk;
        end
        // relax the edge, or flag a negative cycle in the check pass
        SPassCk: begin
          if (check_q && relax_hit) begin
            neg_q   <= 1'b1;
            state_q <= SDone;
          end else begin
            ei_q    <= ei_q + 1'b1;
            state_q <= SPassRd;
            if (relax_hit) begin
              reached_q[cur_q.to] <= 1'b1;
              changed_q           <= 1'b1;
            end
          end
        end
        SDone: if (out_ready_i) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule
